// ===== rtl/md5bc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package md5bc_pkg;

	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned RND_W       = $clog2(ROUNDS);
	localparam int unsigned WIDX_W      = $clog2(BLOCK_WORDS);

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	localparam logic [31:0] SINE_K [ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	typedef enum logic [1:0] {
		PH_F = 2'd0,
		PH_G = 2'd1,
		PH_H = 2'd2,
		PH_I = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_PREP  = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	function automatic logic [WIDX_W-1:0] msg_idx(input logic [RND_W-1:0] r);
		logic [WIDX_W-1:0] r4;
		logic [WIDX_W-1:0] idx;
		r4 = r[WIDX_W-1:0];
		case (phase_t'(r[RND_W-1 -: 2]))
			PH_F: idx = r4;
			PH_G: idx = WIDX_W'(r4 * 4'd5 + 4'd1);
			PH_H: idx = WIDX_W'(r4 * 4'd3 + 4'd5);
			PH_I: idx = WIDX_W'(r4 * 4'd7);
			default: idx = r4;
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [RND_W-1:0] r);
		logic [4:0] s;
		case ({r[RND_W-1 -: 2], r[1:0]})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] mix_fn(input phase_t ph, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] m;
		case (ph)
			PH_F: m = (b & c) | (~b & d);
			PH_G: m = (d & b) | (~d & c);
			PH_H: m = b ^ c ^ d;
			PH_I: m = c ^ (b | ~d);
			default: m = b ^ c ^ d;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] w;
		w = {x, x} << s;
		return w[63:32];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_block_compress_core.sv =====
// MD5 compression core. Sixteen 32-bit message words are taken one item at a time,
// word 0 first; new_message on a word reloads the standard initial chain and makes that
// word the first of a fresh block, dropping any partial block. Words are accepted back
// to back while word_ready is high. After the sixteenth word the core drops word_ready
// while it fetches the first round operand, runs the 64 rounds with one round per cycle
// through a single shared add/rotate datapath, and adds the result into the chain.
// The updated chain appears on chain_a..chain_d with chain_valid and is held in an
// output register, so the next block's words are taken while it waits; the final add
// waits only if the previous result has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module md5_block_compress_core
	import md5bc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] message_word,
	input  wire logic        new_message,
	input  wire logic        word_valid,
	output logic             word_ready,
	output logic [31:0]      chain_a,
	output logic [31:0]      chain_b,
	output logic [31:0]      chain_c,
	output logic [31:0]      chain_d,
	output logic             chain_valid,
	input  wire logic        chain_ready
);

	state_t state_q;
	logic [WIDX_W-1:0] cnt_q;
	logic [RND_W-1:0]  rnd_q;
	logic [31:0] blk_q [BLOCK_WORDS];
	logic [31:0] ha_q, hb_q, hc_q, hd_q;
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [31:0] kw_q;
	logic        out_vld_q;

	logic              acc;
	logic [WIDX_W-1:0] wr_idx;
	logic [RND_W-1:0]  rnd_nxt;
	logic [31:0]       sum;
	logic [31:0]       b_new;
	logic              out_free;

	assign word_ready  = (state_q == ST_LOAD);
	assign acc         = word_valid && word_ready;
	assign wr_idx      = new_message ? '0 : cnt_q;
	assign rnd_nxt     = rnd_q + RND_W'(1);
	assign sum         = mix_fn(phase_t'(rnd_q[RND_W-1 -: 2]), wb_q, wc_q, wd_q)
	                     + wa_q + kw_q;
	assign b_new       = wb_q + rotl32(sum, rot_amt(rnd_q));
	assign out_free    = !out_vld_q || chain_ready;
	assign chain_valid = out_vld_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			blk_q[wr_idx] <= message_word;
		end
		case (state_q)
			ST_PREP: begin
				kw_q <= SINE_K[0] + blk_q[msg_idx('0)];
				wa_q <= ha_q;
				wb_q <= hb_q;
				wc_q <= hc_q;
				wd_q <= hd_q;
			end
			ST_ROUND: begin
				kw_q <= SINE_K[rnd_nxt] + blk_q[msg_idx(rnd_nxt)];
				wa_q <= wd_q;
				wd_q <= wc_q;
				wc_q <= wb_q;
				wb_q <= b_new;
			end
			ST_DONE: begin
				if (out_free) begin
					chain_a <= ha_q + wa_q;
					chain_b <= hb_q + wb_q;
					chain_c <= hc_q + wc_q;
					chain_d <= hd_q + wd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			rnd_q     <= '0;
			out_vld_q <= 1'b0;
			ha_q      <= INIT_A;
			hb_q      <= INIT_B;
			hc_q      <= INIT_C;
			hd_q      <= INIT_D;
		end else begin
			if (out_vld_q && chain_ready && state_q != ST_DONE) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (new_message) begin
							ha_q <= INIT_A;
							hb_q <= INIT_B;
							hc_q <= INIT_C;
							hd_q <= INIT_D;
						end
						cnt_q <= wr_idx + WIDX_W'(1);
						if (wr_idx == WIDX_W'(BLOCK_WORDS - 1)) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_nxt;
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ha_q      <= ha_q + wa_q;
						hb_q      <= hb_q + wb_q;
						hc_q      <= hc_q + wc_q;
						hd_q      <= hd_q + wd_q;
						out_vld_q <= 1'b1;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/md5_block_compress_core_test.sv =====
`timescale 1ns / 1ps

module md5_block_compress_core_test;
	import md5bc_pkg::*;

	typedef struct packed {
		logic [31:0]  word;
		logic         fresh;
		logic         known;
		logic [127:0] digest;
	} seed_row_t;

	localparam int NUM_SEED = 21;
	localparam int NUM_WORDS = 1400;

	localparam logic [31:0] MD5_IV [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROT_AMT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	// digest of the empty message, as chain words A..D
	localparam logic [127:0] EMPTY_MSG_DIGEST = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;

	logic        clk;
	logic        arst_n = 1'b0;
	logic [31:0] message_word = '0;
	logic        new_message = 1'b0;
	logic        word_valid = 1'b0;
	logic        word_ready;
	logic [31:0] chain_a;
	logic [31:0] chain_b;
	logic [31:0] chain_c;
	logic [31:0] chain_d;
	logic        chain_valid;
	logic        chain_ready = 1'b0;

	logic [31:0]  hash_state [4] = MD5_IV;
	logic [31:0]  block_buf [16];
	logic [3:0]   word_idx = '0;
	logic [127:0] pending_digests [$];
	int           sender_idle = 0;
	int           sink_stall = 0;
	int           words_sent = 0;
	int           mismatches = 0;

	// partial blocks first (the flag mid-block drops them), then the empty-message block
	seed_row_t seed_rows [NUM_SEED] = '{
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'hffffffff, 1'b0, 1'b0, 128'h0},
		'{32'h80000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000001, 1'b1, 1'b0, 128'h0},
		'{32'haaaaaaaa, 1'b0, 1'b0, 128'h0},
		'{32'h00000080, 1'b1, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b0, 128'h0},
		'{32'h00000000, 1'b0, 1'b1, EMPTY_MSG_DIGEST}
	};

	md5_block_compress_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.message_word(message_word),
		.new_message(new_message),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.chain_a(chain_a),
		.chain_b(chain_b),
		.chain_c(chain_c),
		.chain_d(chain_d),
		.chain_valid(chain_valid),
		.chain_ready(chain_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic md5_compress();
		logic [31:0] a, b, c, d, mix, sum;
		int idx, s;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		for (int r = 0; r < 64; r++) begin
			case (phase_t'(r / 16))
				PH_F: begin
					mix = (b & c) | (~b & d);
					idx = r;
				end
				PH_G: begin
					mix = (d & b) | (~d & c);
					idx = 5 * r + 1;
				end
				PH_H: begin
					mix = b ^ c ^ d;
					idx = 3 * r + 5;
				end
				default: begin
					mix = c ^ (b | ~d);
					idx = 7 * r;
				end
			endcase
			sum = mix + a + MD5_K[r] + block_buf[idx % 16];
			s = ROT_AMT[(r / 16) * 4 + r % 4];
			a = d;
			d = c;
			c = b;
			b = b + ((sum << s) | (sum >> (32 - s)));
		end
		hash_state[0] = hash_state[0] + a;
		hash_state[1] = hash_state[1] + b;
		hash_state[2] = hash_state[2] + c;
		hash_state[3] = hash_state[3] + d;
	endtask

	task automatic md5_absorb(input logic [31:0] w, input logic fresh, output logic done,
		output logic [127:0] digest);
		if (fresh) begin
			hash_state = MD5_IV;
			word_idx = '0;
		end
		block_buf[word_idx] = w;
		word_idx = word_idx + 4'd1;
		done = (word_idx == 4'd0);
		digest = '0;
		if (done) begin
			md5_compress();
			digest = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
		end
	endtask

	task automatic send_word(input logic [31:0] w, input logic fresh, input logic known,
		input logic [127:0] known_digest);
		logic done;
		logic [127:0] digest;
		word_valid <= 1'b1;
		message_word <= w;
		new_message <= fresh;
		do
			@(posedge clk);
		while (!word_ready);
		md5_absorb(w, fresh, done, digest);
		if (done)
			pending_digests.push_back(known ? known_digest : digest);
		words_sent++;
		while ($urandom_range(99) < sender_idle) begin
			word_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold the sender off until the core has handed back every digest
	task automatic hold_until_drained();
		word_valid <= 1'b0;
		@(posedge clk);
		while (pending_digests.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		int k;
		k = $urandom_range(31);
		case ($urandom_range(9))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return 32'h1 << k;
			3: return ~(32'h1 << k);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] got [4];
		logic [127:0] exp_digest;
		string field_name [4];
		field_name = '{"chain_a", "chain_b", "chain_c", "chain_d"};
		@(posedge arst_n);
		forever begin
			chain_ready <= ($urandom_range(99) >= sink_stall);
			@(posedge clk);
			if (chain_valid && chain_ready) begin
				got = '{chain_a, chain_b, chain_c, chain_d};
				if (pending_digests.size() == 0) begin
					$display("%0t: digest with none expected: %h %h %h %h", $time,
						got[0], got[1], got[2], got[3]);
					mismatches++;
				end else begin
					exp_digest = pending_digests.pop_front();
					for (int i = 0; i < 4; i++)
						if (got[i] !== exp_digest[127 - 32 * i -: 32]) begin
							$display("%0t: %s expected %h actual %h", $time, field_name[i],
								exp_digest[127 - 32 * i -: 32], got[i]);
							mismatches++;
						end
				end
			end
		end
	end

	initial begin
		int blk_no;
		int blk_len;
		int drain;
		logic force_fresh;
		logic fresh;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_SEED; i++)
			send_word(seed_rows[i].word, seed_rows[i].fresh, seed_rows[i].known,
				seed_rows[i].digest);
		hold_until_drained();

		blk_no = 0;
		force_fresh = 1'b0;
		while (words_sent < NUM_SEED + NUM_WORDS) begin
			if (blk_no % 6 == 0) begin
				if (blk_no != 0)
					hold_until_drained();
				case ((blk_no / 6) % 4)
					0: begin
						sender_idle = 0;
						sink_stall = 0;
					end
					1: begin
						sender_idle = 70;
						sink_stall = 0;
					end
					2: begin
						sender_idle = 0;
						sink_stall = 70;
					end
					default: begin
						sender_idle = 25;
						sink_stall = 25;
					end
				endcase
			end
			// one block in eight is cut short; the next one must restart the message
			blk_len = ($urandom_range(7) == 0) ? $urandom_range(1, 15) : 16;
			for (int j = 0; j < blk_len; j++) begin
				if (j == 0)
					fresh = force_fresh | $urandom_range(1);
				else
					fresh = ($urandom_range(63) == 0);
				send_word(pick_word(), fresh, 1'b0, 128'h0);
			end
			force_fresh = (blk_len != 16);
			blk_no++;
		end
		word_valid <= 1'b0;
		sink_stall = 0;

		drain = 0;
		while (pending_digests.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (pending_digests.size() != 0) begin
			$display("%0t: %0d digests never came out", $time, pending_digests.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/md5bc_pkg.sv
rtl/md5_block_compress_core.sv
tb/md5_block_compress_core_test.sv
